// ===== rtl/core/json_string_unescape_top_assert.svh =====
// ============================================================================
// JSON string unescape assertion macros
// Shared assertion forms for the decoder top level.
// ============================================================================
`ifndef JSON_STRING_UNESCAPE_TOP_ASSERT_SVH
`define JSON_STRING_UNESCAPE_TOP_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define JSU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/jsu_pkg.sv =====
// ============================================================================
// JSON string unescape package
// Types, codes and character helpers shared by the decoder modules.
// ============================================================================
package jsu_pkg;

  localparam int unsigned MaxRes = 3;

  localparam logic [15:0] CH_QUOTE  = 16'h0022;
  localparam logic [15:0] CH_BSLASH = 16'h005C;
  localparam logic [15:0] CH_SLASH  = 16'h002F;
  localparam logic [15:0] CH_U      = 16'h0075;

  localparam logic [15:0] HIGH_MIN = 16'hD800;
  localparam logic [15:0] HIGH_MAX = 16'hDBFF;
  localparam logic [15:0] LOW_MIN  = 16'hDC00;
  localparam logic [15:0] LOW_MAX  = 16'hDFFF;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_BODY  = 3'd1,
    MODE_ESC   = 3'd2,
    MODE_HEX   = 3'd3,
    MODE_PWAIT = 3'd4,
    MODE_PBS   = 3'd5,
    MODE_PHEX  = 3'd6
  } mode_e;

  typedef enum logic [3:0] {
    ST_CONT       = 4'd0,
    ST_CLOSED     = 4'd1,
    ST_NOQUOTE    = 4'd2,
    ST_BARE       = 4'd3,
    ST_UNKNOWN    = 4'd4,
    ST_INCOMPLETE = 4'd5,
    ST_BADHEX     = 4'd6,
    ST_BADPAIR    = 4'd7,
    ST_UNTERM     = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    BAD_NONE  = 2'd0,
    BAD_FIRST = 2'd1,
    BAD_PAIR  = 2'd2
  } bad_e;

  typedef struct packed {
    logic [15:0] unit;
    logic        valid;
    status_e     status;
  } res_t;

  typedef struct packed {
    res_t [MaxRes-1:0] res;
    logic [1:0]        count;
  } dec_out_t;

  // Returns {is_hex, digit}.
  function automatic logic [4:0] hex_val(input logic [15:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 16'h0030 && c <= 16'h0039) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 16'h0061 && c <= 16'h0066) || (c >= 16'h0041 && c <= 16'h0046)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // Returns {hit, unit} for the single-character escapes.
  function automatic logic [16:0] esc_map(input logic [15:0] c);
    logic [16:0] r;
    r = 17'd0;
    case (c)
      CH_QUOTE, CH_BSLASH, CH_SLASH: r = {1'b1, c};
      16'h0062: r = {1'b1, 16'h0008};
      16'h0066: r = {1'b1, 16'h000C};
      16'h006E: r = {1'b1, 16'h000A};
      16'h0072: r = {1'b1, 16'h000D};
      16'h0074: r = {1'b1, 16'h0009};
      default:  r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/jsu_decode.sv =====
// ============================================================================
// JSON string unescape decoder
// Holds the parse state and turns one character into up to three results.
// ============================================================================
module jsu_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  logic [15:0]       char_i,
  input  logic              end_i,
  output jsu_pkg::dec_out_t dec_o
);
  import jsu_pkg::*;

  mode_e       mode_q, mode_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [15:0] acc_q, acc_d;
  logic [15:0] high_q, high_d;
  bad_e        bad_q, bad_d;

  always_comb begin
    logic [4:0]  hx;
    logic [16:0] em;
    logic        do_body, do_esc, do_fval, do_unit, do_fin;
    logic [15:0] fval, uval, nacc;
    logic [2:0]  ncnt;
    logic        done;
    status_e     fin_code;
    logic [1:0]  n;
    res_t [MaxRes-1:0] res;

    mode_d   = mode_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    high_d   = high_q;
    bad_d    = bad_q;
    do_body  = 1'b0;
    do_esc   = 1'b0;
    do_fval  = 1'b0;
    do_unit  = 1'b0;
    do_fin   = 1'b0;
    fval     = 16'd0;
    uval     = 16'd0;
    fin_code = ST_CONT;
    n        = 2'd0;
    res      = '0;
    hx       = hex_val(char_i);
    em       = esc_map(char_i);
    nacc     = {acc_q[11:0], hx[3:0] & {4{hx[4]}}};
    ncnt     = cnt_q + 3'd1;
    done     = (ncnt >= 3'd4);

    unique case (mode_q)
      MODE_BODY: do_body = 1'b1;
      MODE_ESC:  do_esc = 1'b1;
      MODE_HEX: begin
        acc_d = nacc;
        cnt_d = ncnt;
        bad_d = hx[4] ? bad_q : BAD_FIRST;
        if (done) begin
          if (bad_d != BAD_NONE) begin
            do_fin   = 1'b1;
            fin_code = ST_BADHEX;
          end else begin
            do_fval = 1'b1;
            fval    = nacc;
          end
        end else if (end_i) begin
          do_fin   = 1'b1;
          fin_code = ST_INCOMPLETE;
        end
      end
      MODE_PWAIT: begin
        if (char_i == CH_BSLASH && !end_i) begin
          mode_d = MODE_PBS;
        end else begin
          res[n] = '{unit: high_q, valid: 1'b1, status: ST_CONT};
          n = n + 2'd1;
          if (char_i == CH_BSLASH) begin
            do_fin   = 1'b1;
            fin_code = ST_BARE;
          end else begin
            do_body = 1'b1;
          end
        end
      end
      MODE_PBS: begin
        if (char_i == CH_U && !end_i) begin
          mode_d = MODE_PHEX;
          cnt_d  = 3'd0;
          acc_d  = 16'd0;
          bad_d  = BAD_NONE;
        end else begin
          res[n] = '{unit: high_q, valid: 1'b1, status: ST_CONT};
          n = n + 2'd1;
          if (char_i == CH_U) begin
            do_fin   = 1'b1;
            fin_code = ST_INCOMPLETE;
          end else begin
            do_esc = 1'b1;
          end
        end
      end
      MODE_PHEX: begin
        acc_d = nacc;
        cnt_d = ncnt;
        bad_d = hx[4] ? bad_q : BAD_PAIR;
        if (done) begin
          if (bad_d != BAD_NONE) begin
            do_fin   = 1'b1;
            fin_code = ST_BADPAIR;
          end else begin
            res[n] = '{unit: high_q, valid: 1'b1, status: ST_CONT};
            n = n + 2'd1;
            if (nacc >= LOW_MIN && nacc <= LOW_MAX) begin
              do_unit = 1'b1;
              uval    = nacc;
            end else begin
              do_fval = 1'b1;
              fval    = nacc;
            end
          end
        end else if (end_i) begin
          res[n] = '{unit: high_q, valid: 1'b1, status: ST_CONT};
          n = n + 2'd1;
          do_fin   = 1'b1;
          fin_code = ST_INCOMPLETE;
        end
      end
      default: begin
        if (char_i == CH_QUOTE) begin
          if (end_i) begin
            do_fin   = 1'b1;
            fin_code = ST_UNTERM;
          end else begin
            mode_d = MODE_BODY;
          end
        end else begin
          do_fin   = 1'b1;
          fin_code = ST_NOQUOTE;
        end
      end
    endcase

    if (do_body) begin
      if (char_i == CH_QUOTE) begin
        do_fin   = 1'b1;
        fin_code = ST_CLOSED;
      end else if (char_i == CH_BSLASH) begin
        if (end_i) begin
          do_fin   = 1'b1;
          fin_code = ST_BARE;
        end else begin
          mode_d = MODE_ESC;
        end
      end else begin
        do_unit = 1'b1;
        uval    = char_i;
      end
    end

    if (do_esc) begin
      if (em[16]) begin
        do_unit = 1'b1;
        uval    = em[15:0];
      end else if (char_i == CH_U) begin
        if (end_i) begin
          do_fin   = 1'b1;
          fin_code = ST_INCOMPLETE;
        end else begin
          mode_d = MODE_HEX;
          cnt_d  = 3'd0;
          acc_d  = 16'd0;
          bad_d  = BAD_NONE;
        end
      end else begin
        do_fin   = 1'b1;
        fin_code = ST_UNKNOWN;
      end
    end

    if (do_fval) begin
      if (fval >= HIGH_MIN && fval <= HIGH_MAX) begin
        high_d = fval;
        if (end_i) begin
          res[n] = '{unit: fval, valid: 1'b1, status: ST_CONT};
          n = n + 2'd1;
          do_fin   = 1'b1;
          fin_code = ST_UNTERM;
        end else begin
          mode_d = MODE_PWAIT;
        end
      end else begin
        do_unit = 1'b1;
        uval    = fval;
      end
    end

    if (do_unit) begin
      res[n] = '{unit: uval, valid: 1'b1, status: ST_CONT};
      n = n + 2'd1;
      mode_d = MODE_BODY;
      if (end_i) begin
        do_fin   = 1'b1;
        fin_code = ST_UNTERM;
      end
    end

    if (do_fin) begin
      res[n] = '{unit: 16'd0, valid: 1'b0, status: fin_code};
      n = n + 2'd1;
      mode_d = MODE_IDLE;
    end

    dec_o.res   = res;
    dec_o.count = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      cnt_q  <= 3'd0;
      acc_q  <= 16'd0;
      high_q <= 16'd0;
      bad_q  <= BAD_NONE;
    end else if (advance_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
      high_q <= high_d;
      bad_q  <= bad_d;
    end
  end

endmodule

// ===== rtl/core/jsu_outbuf.sv =====
// ============================================================================
// JSON string unescape result buffer
// Holds the results of one item and hands them out one per cycle while pop_i takes them.
// ============================================================================
module jsu_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  jsu_pkg::dec_out_t dec_i,
  input  logic              pop_i,
  output logic              load_ok_o,
  output logic              valid_o,
  output logic              last_o,
  output jsu_pkg::res_t     res_o
);
  import jsu_pkg::*;

  res_t [MaxRes-1:0] buf_q;
  logic [1:0]        cnt_q, cnt_d;
  logic [1:0]        rd_q, rd_d;
  logic              on_last;

  assign valid_o   = (rd_q < cnt_q);
  assign on_last   = (rd_q == cnt_q - 2'd1);
  assign last_o    = on_last;
  assign res_o     = buf_q[rd_q];
  assign load_ok_o = !valid_o || (pop_i && on_last);

  always_comb begin
    cnt_d = cnt_q;
    rd_d  = rd_q;
    if (load_i) begin
      cnt_d = dec_i.count;
      rd_d  = 2'd0;
    end else if (pop_i && valid_o) begin
      rd_d = rd_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= dec_i.res;
    end
  end

endmodule

// ===== rtl/core/json_string_unescape_top.sv =====
// An accepted item is registered at the input, then decoded into the result buffer.
// Throughput: one item per cycle while each item yields at most one result and
// m_axis_tready is high; the buffer takes a new item only once its last result goes.
// Reset: rst_ni clears the parse state to idle (awaiting an opening quote) and
// empties the input register and result buffer at once.
// ============================================================================
// JSON string unescape top level
// Decodes a UTF-16 JSON string body into code units and a final status.
// ============================================================================
`include "json_string_unescape_top_assert.svh"

module json_string_unescape_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] char_in
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [15:0] unit_out, [19:16] status
  output logic        m_axis_tuser,  // [0] unit_valid
  output logic        m_axis_tlast
);
  import jsu_pkg::*;

  logic        in_valid_q;
  logic [15:0] in_char_q;
  logic        in_end_q;
  logic        advance;
  logic        load_ok;
  logic        pop;
  logic        out_valid;
  logic        out_last;
  res_t        out_res;
  dec_out_t    dec;

  assign advance       = in_valid_q && load_ok;
  assign s_axis_tready = !in_valid_q || advance;
  assign pop           = out_valid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata;
      in_end_q  <= s_axis_tlast;
    end
  end

  jsu_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .char_i    (in_char_q),
    .end_i     (in_end_q),
    .dec_o     (dec)
  );

  jsu_outbuf u_outbuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (advance),
    .dec_i     (dec),
    .pop_i     (pop),
    .load_ok_o (load_ok),
    .valid_o   (out_valid),
    .last_o    (out_last),
    .res_o     (out_res)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {4'b0000, out_res.status, out_res.unit};
  assign m_axis_tuser  = out_res.valid;

  `JSU_ASSERT_SAME(a_stall_holds_input, !s_axis_tready, in_valid_q && !advance,
                   "input stalled without a held item")
  `JSU_ASSERT_SAME(a_status_is_last, out_valid && !out_res.valid, out_last,
                   "status result not last of its item")
  `JSU_ASSERT_SAME(a_unit_has_no_status, out_valid && out_res.valid,
                   out_res.status == ST_CONT, "unit result carries a status")
  `JSU_ASSERT_NEXT(a_advance_frees_input, advance && !(s_axis_tvalid && s_axis_tready),
                   !in_valid_q, "input register not freed")

endmodule

// ===== tb/sv/json_string_unescape_top_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// JSON string unescape top level testbench
// Streams UTF-16 characters into the decoder and checks each result item
// against a cycle-free model of the parser. Short directed strings cover the
// opening quote, escapes, surrogate pairs and early source ends. Random
// strings then run under several sender and receiver idling patterns.
// ============================================================================
module json_string_unescape_top_tb;
  import jsu_pkg::*;

  localparam int STUCK_LIMIT = 2000;

  localparam logic [15:0] ESC_B = "b";
  localparam logic [15:0] ESC_F = "f";
  localparam logic [15:0] ESC_N = "n";
  localparam logic [15:0] ESC_R = "r";
  localparam logic [15:0] ESC_T = "t";

  typedef struct packed {
    logic [23:0] word;
    logic        user;
    logic        last;
  } out_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = 16'h0000;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  json_string_unescape_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Parser model state.
  mode_e       dec_mode = MODE_IDLE;
  logic [2:0]  slot_cnt = 3'd0;
  logic [15:0] hex_acc = 16'h0000;
  logic [15:0] held_hi = 16'h0000;
  bad_e        bad_digit = BAD_NONE;

  out_item_t   expected_q[$];
  out_item_t   step_q[$];
  logic [15:0] text_q[$];
  int          end_at;

  int send_idle_pct = 0;
  int rx_stall_pct = 0;
  int items_sent = 0;
  int error_cnt = 0;
  int stuck_cycles = 0;

  task automatic report_error(input string msg);
    error_cnt++;
    if (error_cnt <= 100) begin
      $display("%0t ERROR %s", $time, msg);
    end
  endtask

  task automatic put_result(input logic [15:0] u, input logic v, input status_e st);
    out_item_t r;
    if (step_q.size() < MaxRes) begin
      r.word = {4'b0000, st, u};
      r.user = v;
      r.last = 1'b0;
      step_q.insert(step_q.size(), r);
    end
  endtask

  task automatic close_with(input status_e st);
    put_result(16'h0000, 1'b0, st);
    dec_mode = MODE_IDLE;
  endtask

  task automatic emit_char(input logic [15:0] u, input logic fin);
    put_result(u, 1'b1, ST_CONT);
    dec_mode = MODE_BODY;
    if (fin) begin
      close_with(ST_UNTERM);
    end
  endtask

  function automatic int hex_digit(input logic [15:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "a" && c <= "f") return int'(c) - 87;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    return -1;
  endfunction

  task automatic body_char_in(input logic [15:0] c, input logic fin);
    if (c == CH_QUOTE) begin
      close_with(ST_CLOSED);
    end else if (c == CH_BSLASH) begin
      if (fin) close_with(ST_BARE);
      else dec_mode = MODE_ESC;
    end else begin
      emit_char(c, fin);
    end
  endtask

  task automatic begin_hex(input mode_e m);
    dec_mode = m;
    slot_cnt = 3'd0;
    hex_acc = 16'h0000;
    bad_digit = BAD_NONE;
  endtask

  task automatic escape_in(input logic [15:0] c, input logic fin);
    case (c)
      CH_QUOTE, CH_BSLASH, CH_SLASH: emit_char(c, fin);
      ESC_B: emit_char(16'h0008, fin);
      ESC_F: emit_char(16'h000C, fin);
      ESC_N: emit_char(16'h000A, fin);
      ESC_R: emit_char(16'h000D, fin);
      ESC_T: emit_char(16'h0009, fin);
      CH_U: begin
        if (fin) close_with(ST_INCOMPLETE);
        else begin_hex(MODE_HEX);
      end
      default: close_with(ST_UNKNOWN);
    endcase
  endtask

  task automatic value_done(input logic [15:0] v, input logic fin);
    if (v >= HIGH_MIN && v <= HIGH_MAX) begin
      held_hi = v;
      if (fin) begin
        put_result(v, 1'b1, ST_CONT);
        close_with(ST_UNTERM);
      end else begin
        dec_mode = MODE_PWAIT;
      end
    end else begin
      emit_char(v, fin);
    end
  endtask

  task automatic hex_slot(input logic [15:0] c, input bad_e code, output bit full);
    int d;
    d = hex_digit(c);
    if (d < 0) begin
      bad_digit = code;
      d = 0;
    end
    hex_acc = {hex_acc[11:0], 4'(d)};
    slot_cnt = slot_cnt + 3'd1;
    full = (slot_cnt >= 3'd4);
  endtask

  // Works out the result items one input character causes.
  task automatic decode_char(input logic [15:0] c, input logic fin);
    bit full;
    step_q.delete();
    case (dec_mode)
      MODE_BODY: body_char_in(c, fin);
      MODE_ESC: escape_in(c, fin);
      MODE_HEX: begin
        hex_slot(c, BAD_FIRST, full);
        if (full) begin
          if (bad_digit != BAD_NONE) close_with(ST_BADHEX);
          else value_done(hex_acc, fin);
        end else if (fin) begin
          close_with(ST_INCOMPLETE);
        end
      end
      MODE_PWAIT: begin
        if (c == CH_BSLASH) begin
          if (fin) begin
            put_result(held_hi, 1'b1, ST_CONT);
            close_with(ST_BARE);
          end else begin
            dec_mode = MODE_PBS;
          end
        end else begin
          put_result(held_hi, 1'b1, ST_CONT);
          body_char_in(c, fin);
        end
      end
      MODE_PBS: begin
        if (c == CH_U) begin
          if (fin) begin
            put_result(held_hi, 1'b1, ST_CONT);
            close_with(ST_INCOMPLETE);
          end else begin
            begin_hex(MODE_PHEX);
          end
        end else begin
          put_result(held_hi, 1'b1, ST_CONT);
          escape_in(c, fin);
        end
      end
      MODE_PHEX: begin
        hex_slot(c, BAD_PAIR, full);
        if (full) begin
          if (bad_digit != BAD_NONE) begin
            close_with(ST_BADPAIR);
          end else if (hex_acc >= LOW_MIN && hex_acc <= LOW_MAX) begin
            put_result(held_hi, 1'b1, ST_CONT);
            emit_char(hex_acc, fin);
          end else begin
            put_result(held_hi, 1'b1, ST_CONT);
            value_done(hex_acc, fin);
          end
        end else if (fin) begin
          put_result(held_hi, 1'b1, ST_CONT);
          close_with(ST_INCOMPLETE);
        end
      end
      default: begin
        if (c == CH_QUOTE) begin
          if (fin) close_with(ST_UNTERM);
          else dec_mode = MODE_BODY;
        end else begin
          close_with(ST_NOQUOTE);
        end
      end
    endcase
    if (step_q.size() > 0) begin
      step_q[step_q.size() - 1].last = 1'b1;
    end
    foreach (step_q[i]) expected_q.insert(expected_q.size(), step_q[i]);
  endtask

  task automatic push_char(input logic [15:0] c, input logic fin);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    s_axis_tlast <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_char(c, fin);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic append_char(input logic [15:0] c);
    text_q.insert(text_q.size(), c);
  endtask

  function automatic logic [15:0] nib_char(input logic [3:0] n);
    if (n < 4'd10) return 16'h0030 + 16'(n);
    return ($urandom_range(0, 1) ? 16'h0041 : 16'h0061) + 16'(n) - 16'd10;
  endfunction

  function automatic logic [15:0] rand_nonhex();
    return $urandom_range(0, 1) ? 16'h0067 : 16'($urandom_range(16'h0100, 16'hFFFF));
  endfunction

  function automatic logic [15:0] rand_plain();
    return $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(16'h0020, 16'h007E));
  endfunction

  function automatic logic [15:0] rand_high();
    return HIGH_MIN | 16'($urandom_range(0, 10'h3FF));
  endfunction

  function automatic logic [15:0] rand_low();
    return LOW_MIN | 16'($urandom_range(0, 10'h3FF));
  endfunction

  function automatic logic [15:0] rand_unknown();
    case ($urandom_range(0, 2))
      0: return "x";
      1: return "U";
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] escape_letter(input int k);
    case (k)
      0: return CH_QUOTE;
      1: return CH_BSLASH;
      2: return CH_SLASH;
      3: return ESC_B;
      4: return ESC_F;
      5: return ESC_N;
      6: return ESC_R;
      default: return ESC_T;
    endcase
  endfunction

  task automatic add_uescape(input logic [15:0] v, input int bad_pos);
    append_char(CH_BSLASH);
    append_char(CH_U);
    for (int i = 3; i >= 0; i--) begin
      append_char((i == bad_pos) ? rand_nonhex() : nib_char(v[4*i +: 4]));
    end
  endtask

  // Mostly well-formed strings with random content, some noise and cut-offs.
  task automatic build_string();
    int kind;
    int cut;
    text_q.delete();
    end_at = -1;
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 2)) append_char(16'($urandom));
      if ($urandom_range(0, 3) == 0) end_at = text_q.size() - 1;
      return;
    end
    append_char(CH_QUOTE);
    repeat ($urandom_range(0, 5)) begin
      kind = $urandom_range(0, 99);
      if (kind < 28) begin
        append_char(rand_plain());
      end else if (kind < 46) begin
        append_char(CH_BSLASH);
        append_char(escape_letter($urandom_range(0, 7)));
      end else if (kind < 60) begin
        add_uescape(16'($urandom), -1);
      end else if (kind < 74) begin
        add_uescape(rand_high(), -1);
        add_uescape(rand_low(), -1);
      end else if (kind < 82) begin
        add_uescape(rand_high(), -1);
      end else if (kind < 86) begin
        add_uescape(rand_high(), -1);
        add_uescape(16'($urandom), -1);
      end else if (kind < 90) begin
        add_uescape(16'($urandom), $urandom_range(0, 3));
      end else if (kind < 94) begin
        add_uescape(rand_high(), -1);
        add_uescape(rand_low(), $urandom_range(0, 3));
      end else if (kind < 97) begin
        append_char(CH_BSLASH);
        append_char(rand_unknown());
      end else begin
        add_uescape(rand_high(), -1);
        append_char(CH_BSLASH);
        append_char(rand_unknown());
      end
    end
    append_char(CH_QUOTE);
    cut = $urandom_range(0, 99);
    if (cut < 25) end_at = $urandom_range(0, text_q.size() - 1);
    else if (cut < 30) end_at = text_q.size() - 1;
  endtask

  task automatic send_text();
    int n;
    n = (end_at < 0) ? text_q.size() : end_at + 1;
    for (int i = 0; i < n; i++) begin
      push_char(text_q[i], i == end_at);
    end
  endtask

  task automatic test_open_quote();
    push_char(16'h0000, 1'b0);
    push_char(CH_QUOTE, 1'b1);
  endtask

  task automatic test_escapes_and_pairs();
    push_char(CH_QUOTE, 1'b0);
    push_char(16'hFFFF, 1'b0);
    push_char(CH_BSLASH, 1'b0);
    push_char(CH_SLASH, 1'b0);
    push_char(CH_BSLASH, 1'b0);
    push_char(CH_U, 1'b0);
    push_char("D", 1'b0);
    push_char("8", 1'b0);
    push_char("3", 1'b0);
    push_char("d", 1'b0);
    push_char(CH_BSLASH, 1'b0);
    push_char(CH_U, 1'b0);
    push_char("d", 1'b0);
    push_char("E", 1'b0);
    push_char("0", 1'b0);
    push_char("0", 1'b0);
    push_char(CH_QUOTE, 1'b0);
  endtask

  task automatic test_early_end();
    push_char(CH_QUOTE, 1'b0);
    push_char(CH_BSLASH, 1'b0);
    push_char(CH_U, 1'b0);
    push_char("g", 1'b1);
    push_char(CH_QUOTE, 1'b0);
    push_char(CH_BSLASH, 1'b1);
  endtask

  task automatic test_random_strings(input int idle_pct, input int stall_pct,
                                     input int n_items, input bit pause_midway);
    int  start_cnt;
    bit  paused;
    send_idle_pct = idle_pct;
    rx_stall_pct = stall_pct;
    start_cnt = items_sent;
    paused = 1'b0;
    while (items_sent - start_cnt < n_items) begin
      build_string();
      send_text();
      if (pause_midway && !paused && items_sent - start_cnt >= n_items / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
    wait_drained();
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    out_item_t got;
    out_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.word = m_axis_tdata;
      got.user = m_axis_tuser;
      got.last = m_axis_tlast;
      if (expected_q.size() == 0) begin
        report_error($sformatf("unexpected item data %h user %b last %b",
                               got.word, got.user, got.last));
      end else begin
        want = expected_q.pop_front();
        if (got != want) begin
          report_error($sformatf(
            "unit %h/%h valid %b/%b status %0d/%0d pad %b last %b/%b (got/want)",
            got.word[15:0], want.word[15:0], got.user, want.user,
            got.word[19:16], want.word[19:16], got.word[23:20], got.last, want.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_open_quote();
    test_escapes_and_pairs();
    test_early_end();
    wait_drained();

    test_random_strings(0, 0, 90, 1'b1);
    test_random_strings(86, 0, 90, 1'b0);
    test_random_strings(0, 86, 90, 1'b0);
    test_random_strings(22, 22, 90, 1'b0);

    repeat (8) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
